/* rtl/rpi_pkg.sv */
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared constants and register codes of the ray / plane intersection block.
// ----------------------------------------------------------------------------
package rpi_pkg;

  // plane normal components: signed Q1.14
  localparam int NORM_WIDTH   = 16;
  localparam int NORM_FRAC    = 14;
  // scalar fields: plane offset, ray parameter, limit, texture coordinates
  localparam int SCALAR_WIDTH = 24;
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_NORMAL   = 3'd0,
    REG_PLANE_OFFSET   = 3'd1,
    REG_TEXTURE_ORIGIN = 3'd2,
    REG_TEXTURE_U_AXIS = 3'd3,
    REG_TEXTURE_V_AXIS = 3'd4
  } rpi_reg_e;

endpackage

/* rtl/rpi_ray_if.sv */
// ----------------------------------------------------------------------------
// rpi_ray_if / rpi_result_if
// Valid / ready channels carrying one ray and one intersection result.
// ----------------------------------------------------------------------------
interface rpi_ray_if #(
  parameter int COORD_WIDTH = 20
) ();
  logic                                   valid;
  logic                                   ready;
  logic signed [COORD_WIDTH-1:0]          origin_x;
  logic signed [COORD_WIDTH-1:0]          origin_y;
  logic signed [COORD_WIDTH-1:0]          origin_z;
  logic signed [COORD_WIDTH-1:0]          dir_x;
  logic signed [COORD_WIDTH-1:0]          dir_y;
  logic signed [COORD_WIDTH-1:0]          dir_z;
  logic [rpi_pkg::SCALAR_WIDTH-1:0]       max_distance;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  max_distance, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  max_distance, output ready);
endinterface

interface rpi_result_if #(
  parameter int COORD_WIDTH = 20
) ();
  logic                                   valid;
  logic                                   ready;
  logic                                   hit;
  logic                                   not_parallel;
  logic [rpi_pkg::SCALAR_WIDTH-1:0]       hit_distance;
  logic signed [COORD_WIDTH-1:0]          point_x;
  logic signed [COORD_WIDTH-1:0]          point_y;
  logic signed [COORD_WIDTH-1:0]          point_z;
  logic signed [rpi_pkg::SCALAR_WIDTH-1:0] tex_s;
  logic signed [rpi_pkg::SCALAR_WIDTH-1:0] tex_t;

  modport source (output valid, hit, not_parallel, hit_distance, point_x, point_y, point_z,
                  tex_s, tex_t, input ready);
  modport sink   (input valid, hit, not_parallel, hit_distance, point_x, point_y, point_z,
                  tex_s, tex_t, output ready);
endinterface

/* rtl/rpi_div_pipe.sv */
// ----------------------------------------------------------------------------
// rpi_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with overflow
// flag for quotients of 2^QW and above. Several lanes share the handshake.
// ----------------------------------------------------------------------------
module rpi_div_pipe #(
  parameter int LANES = 1,
  parameter int NW    = 51,
  parameter int DW    = 38,
  parameter int QW    = 24,
  parameter int PW    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [NW-1:0] num_i [LANES],
  input  logic [DW-1:0] den_i [LANES],
  input  logic [PW-1:0] pay_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [QW-1:0] quo_o [LANES],
  output logic [LANES-1:0] ovf_o,
  output logic [PW-1:0] pay_o
);

  localparam int S  = QW + 1;
  localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [S-1:0]  v_q;
  logic [S-1:0]  en;
  logic [RW-1:0] rem_q [S][LANES];
  logic [DW-1:0] den_q [S][LANES];
  logic [QW-1:0] quo_q [S][LANES];
  logic          ovf_q [S][LANES];
  logic [PW-1:0] pay_q [S];

  always_comb begin
    en[S-1] = !v_q[S-1] || out_ready_i;
    for (int s = S - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < S; s++) begin
        if (en[s]) begin
          v_q[s] <= (s == 0) ? in_valid_i : v_q[s-1];
        end
      end
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_st
    if (k == 0) begin : g_pay0
      always_ff @(posedge clk_i) begin
        if (en[k]) pay_q[k] <= pay_i;
      end
    end else begin : g_payn
      always_ff @(posedge clk_i) begin
        if (en[k]) pay_q[k] <= pay_q[k-1];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_ln
      logic [RW-1:0] rem_in, dsh, rem_nx;
      logic [DW-1:0] den_in;
      logic [QW-1:0] quo_in, quo_nx;
      logic          ovf_in, ovf_nx;

      if (k == 0) begin : g_src0
        assign rem_in = RW'(num_i[l]);
        assign den_in = den_i[l];
        assign quo_in = '0;
        assign ovf_in = 1'b0;
      end else begin : g_srcn
        assign rem_in = rem_q[k-1][l];
        assign den_in = den_q[k-1][l];
        assign quo_in = quo_q[k-1][l];
        assign ovf_in = ovf_q[k-1][l];
      end

      if (k == 0) begin : g_ovf
        // quotient would need more than QW bits
        assign dsh    = RW'(den_in) << QW;
        assign ovf_nx = (rem_in >= dsh) || ovf_in;
        assign rem_nx = rem_in;
        assign quo_nx = quo_in;
      end else begin : g_bit
        assign dsh    = RW'(den_in) << (QW - k);
        assign ovf_nx = ovf_in;
        always_comb begin
          if (!ovf_in && rem_in >= dsh) begin
            rem_nx = rem_in - dsh;
            quo_nx = quo_in | (QW'(1) << (QW - k));
          end else begin
            rem_nx = rem_in;
            quo_nx = quo_in;
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          rem_q[k][l] <= rem_nx;
          den_q[k][l] <= den_in;
          quo_q[k][l] <= quo_nx;
          ovf_q[k][l] <= ovf_nx;
        end
      end

      if (k == S - 1) begin : g_out
        assign quo_o[l] = quo_q[k][l];
        assign ovf_o[l] = ovf_q[k][l];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[S-1];
  assign pay_o       = pay_q[S-1];

endmodule

/* rtl/rpi_plane_dot.sv */
// ----------------------------------------------------------------------------
// rpi_plane_dot
// Dot products of the plane normal with ray direction and origin, and the
// set-up of the ray parameter division.
// ----------------------------------------------------------------------------
module rpi_plane_dot #(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 12,
  localparam int W    = COORD_WIDTH,
  localparam int NW   = rpi_pkg::NORM_WIDTH,
  localparam int SW   = rpi_pkg::SCALAR_WIDTH,
  localparam int PRW  = NW + W + 2,
  localparam int NUMW = ((SW + rpi_pkg::NORM_FRAC > PRW) ? SW + rpi_pkg::NORM_FRAC : PRW) + 1,
  localparam int DNW  = NUMW + FRAC_BITS,
  localparam int PAYW = 6 * W + SW + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [W-1:0]  org_i [3],
  input  logic signed [W-1:0]  dir_i [3],
  input  logic [SW-1:0]        limit_i,
  input  logic [3*NW-1:0]      normal_i,
  input  logic signed [SW-1:0] offset_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DNW-1:0]       num_o,
  output logic [PRW-1:0]       den_o,
  output logic [PAYW-1:0]      pay_o
);

  localparam int PMW = NW + W;

  logic [2:0] v_q;
  logic [2:0] en;

  logic signed [NW-1:0]  nrm [3];
  logic signed [PMW-1:0] pd_q [3];
  logic signed [PMW-1:0] po_q [3];
  logic signed [W-1:0]   orga_q [3], dira_q [3];
  logic [SW-1:0]         lima_q;

  logic signed [PRW-1:0]  den_d, den_q;
  logic signed [NUMW-1:0] num_d, num_q;
  logic signed [W-1:0]    orgb_q [3], dirb_q [3];
  logic [SW-1:0]          limb_q;

  logic [NUMW-1:0]     absn;
  logic [PRW-1:0]      absd;
  logic [DNW-1:0]      numc_q;
  logic [PRW-1:0]      denc_q;
  logic                pos_q, np_q;
  logic signed [W-1:0] orgc_q [3], dirc_q [3];
  logic [SW-1:0]       limc_q;

  always_comb begin
    en[2] = !v_q[2] || out_ready_i;
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_nrm
    assign nrm[i] = normal_i[NW*i +: NW];
  end

  // stage a: six products
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        pd_q[i]   <= PMW'(nrm[i]) * PMW'(dir_i[i]);
        po_q[i]   <= PMW'(nrm[i]) * PMW'(org_i[i]);
        orga_q[i] <= org_i[i];
        dira_q[i] <= dir_i[i];
      end
      lima_q <= limit_i;
    end
  end

  // stage b: sums, offset lifted to the normal's fraction
  always_comb begin
    den_d = PRW'(pd_q[0]) + PRW'(pd_q[1]) + PRW'(pd_q[2]);
    num_d = (NUMW'(offset_i) <<< rpi_pkg::NORM_FRAC)
          + NUMW'(po_q[0]) + NUMW'(po_q[1]) + NUMW'(po_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      den_q  <= den_d;
      num_q  <= num_d;
      orgb_q <= orga_q;
      dirb_q <= dira_q;
      limb_q <= lima_q;
    end
  end

  // stage c: magnitudes and sign of t
  always_comb begin
    absn = num_q[NUMW-1] ? NUMW'(-num_q) : NUMW'(num_q);
    absd = den_q[PRW-1]  ? PRW'(-den_q)  : PRW'(den_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      numc_q <= {absn, {FRAC_BITS{1'b0}}};
      denc_q <= absd;
      pos_q  <= (den_q != '0) && (num_q != '0) && (num_q[NUMW-1] != den_q[PRW-1]);
      np_q   <= (den_q != '0);
      orgc_q <= orgb_q;
      dirc_q <= dirb_q;
      limc_q <= limb_q;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[2];
  assign num_o       = numc_q;
  assign den_o       = denc_q;
  assign pay_o       = {orgc_q[2], orgc_q[1], orgc_q[0], dirc_q[2], dirc_q[1], dirc_q[0],
                        limc_q, pos_q, np_q};

endmodule

/* rtl/rpi_hit_tex.sv */
// ----------------------------------------------------------------------------
// rpi_hit_tex
// Hit decision, hit point, and the texture axis products and set-up of the
// two texture coordinate divisions.
// ----------------------------------------------------------------------------
module rpi_hit_tex #(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 12,
  localparam int W    = COORD_WIDTH,
  localparam int SW   = rpi_pkg::SCALAR_WIDTH,
  localparam int PAYW = 6 * W + SW + 2,
  localparam int DOTW = 2 * W + 3,
  localparam int LENW = 2 * W + 2,
  localparam int TNW  = DOTW + FRAC_BITS,
  localparam int PAY2 = SW + 3 * W + 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [SW-1:0]   quo_i,
  input  logic            ovf_i,
  input  logic [PAYW-1:0] pay_i,
  input  logic [3*W-1:0]  torg_i,
  input  logic [3*W-1:0]  tu_i,
  input  logic [3*W-1:0]  tv_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [TNW-1:0]  num_o [2],
  output logic [LENW-1:0] den_o [2],
  output logic [PAY2-1:0] pay_o
);

  localparam int S    = 5;
  localparam int MULW = W + SW;
  localparam int STW  = W + SW - FRAC_BITS;
  localparam int PSW  = STW + 2;
  localparam int DSW  = W + 1;
  localparam int DPW  = 2 * W + 1;

  logic [S-1:0] v_q;
  logic [S-1:0] en;

  // unpacked input item
  logic                np_in, pos_in;
  logic [SW-1:0]       lim_in;
  logic signed [W-1:0] org_in [3], dir_in [3];
  logic [W-1:0]        mag_in [3];
  logic signed [W-1:0] q0 [3], ua [3], va [3];

  logic [MULW-1:0]     prod1_q [3];
  logic                dneg1_q [3];
  logic signed [W-1:0] org1_q [3];
  logic                hit1_q, np1_q;
  logic [SW-1:0]       tq1_q;

  logic signed [W-1:0]   pt_d [3];
  logic signed [DSW-1:0] dist_d [3];
  logic signed [W-1:0]   pt2_q [3];
  logic signed [DSW-1:0] dist2_q [3];
  logic                  hit2_q, np2_q;
  logic [SW-1:0]         tq2_q;

  logic signed [DPW-1:0] du3_q [3], dv3_q [3];
  logic [2*W-1:0]        uu3_q [3], vv3_q [3];
  logic signed [W-1:0]   pt3_q [3];
  logic                  hit3_q, np3_q;
  logic [SW-1:0]         tq3_q;

  logic signed [DOTW-1:0] ds4_q, dt4_q;
  logic [LENW-1:0]        ls4_q, lt4_q;
  logic signed [W-1:0]    pt4_q [3];
  logic                   hit4_q, np4_q;
  logic [SW-1:0]          tq4_q;

  logic [DOTW-1:0]     abss, abst;
  logic [TNW-1:0]      ns5_q, nt5_q;
  logic [LENW-1:0]     ls5_q, lt5_q;
  logic                negs5_q, negt5_q, zs5_q, zt5_q;
  logic signed [W-1:0] pt5_q [3];
  logic                hit5_q, np5_q;
  logic [SW-1:0]       tq5_q;

  always_comb begin
    en[S-1] = !v_q[S-1] || out_ready_i;
    for (int s = S - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < S; s++) begin
        if (en[s]) begin
          v_q[s] <= (s == 0) ? in_valid_i : v_q[s-1];
        end
      end
    end
  end

  assign np_in  = pay_i[0];
  assign pos_in = pay_i[1];
  assign lim_in = pay_i[2 +: SW];

  for (genvar i = 0; i < 3; i++) begin : g_unp
    assign dir_in[i] = pay_i[SW + 2 + W*i +: W];
    assign org_in[i] = pay_i[SW + 2 + 3*W + W*i +: W];
    assign mag_in[i] = dir_in[i][W-1] ? W'(-dir_in[i]) : W'(dir_in[i]);
    assign q0[i]     = torg_i[W*i +: W];
    assign ua[i]     = tu_i[W*i +: W];
    assign va[i]     = tv_i[W*i +: W];
  end

  // stage 1: hit decision and |dir| * t
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        prod1_q[i] <= MULW'(mag_in[i]) * MULW'(quo_i);
        dneg1_q[i] <= dir_in[i][W-1];
        org1_q[i]  <= org_in[i];
      end
      hit1_q <= pos_in && !ovf_i && (quo_i != '0) && (quo_i < lim_in);
      np1_q  <= np_in;
      tq1_q  <= quo_i;
    end
  end

  // stage 2: point, saturated, and offset from the texture origin
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [PSW-1:0] stp, p;
      stp = PSW'(prod1_q[i] >> FRAC_BITS);
      p   = dneg1_q[i] ? PSW'(org1_q[i]) - stp : PSW'(org1_q[i]) + stp;
      if (p[PSW-1:W-1] != {(PSW-W+1){p[PSW-1]}}) begin
        pt_d[i] = p[PSW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        pt_d[i] = p[W-1:0];
      end
      dist_d[i] = DSW'(pt_d[i]) - DSW'(q0[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pt2_q   <= pt_d;
      dist2_q <= dist_d;
      hit2_q  <= hit1_q;
      np2_q   <= np1_q;
      tq2_q   <= tq1_q;
    end
  end

  // stage 3: axis products
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        du3_q[i] <= DPW'(dist2_q[i]) * DPW'(ua[i]);
        dv3_q[i] <= DPW'(dist2_q[i]) * DPW'(va[i]);
        uu3_q[i] <= (2*W)'((2*W)'(ua[i]) * (2*W)'(ua[i]));
        vv3_q[i] <= (2*W)'((2*W)'(va[i]) * (2*W)'(va[i]));
      end
      pt3_q  <= pt2_q;
      hit3_q <= hit2_q;
      np3_q  <= np2_q;
      tq3_q  <= tq2_q;
    end
  end

  // stage 4: sums
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ds4_q  <= DOTW'(du3_q[0]) + DOTW'(du3_q[1]) + DOTW'(du3_q[2]);
      dt4_q  <= DOTW'(dv3_q[0]) + DOTW'(dv3_q[1]) + DOTW'(dv3_q[2]);
      ls4_q  <= LENW'(uu3_q[0]) + LENW'(uu3_q[1]) + LENW'(uu3_q[2]);
      lt4_q  <= LENW'(vv3_q[0]) + LENW'(vv3_q[1]) + LENW'(vv3_q[2]);
      pt4_q  <= pt3_q;
      hit4_q <= hit3_q;
      np4_q  <= np3_q;
      tq4_q  <= tq3_q;
    end
  end

  // stage 5: magnitudes and signs for the two divisions
  always_comb begin
    abss = ds4_q[DOTW-1] ? DOTW'(-ds4_q) : DOTW'(ds4_q);
    abst = dt4_q[DOTW-1] ? DOTW'(-dt4_q) : DOTW'(dt4_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      ns5_q   <= {abss, {FRAC_BITS{1'b0}}};
      nt5_q   <= {abst, {FRAC_BITS{1'b0}}};
      ls5_q   <= ls4_q;
      lt5_q   <= lt4_q;
      negs5_q <= ds4_q[DOTW-1];
      negt5_q <= dt4_q[DOTW-1];
      zs5_q   <= (ls4_q == '0);
      zt5_q   <= (lt4_q == '0);
      pt5_q   <= pt4_q;
      hit5_q  <= hit4_q;
      np5_q   <= np4_q;
      tq5_q   <= tq4_q;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[S-1];
  assign num_o[0]    = ns5_q;
  assign num_o[1]    = nt5_q;
  assign den_o[0]    = ls5_q;
  assign den_o[1]    = lt5_q;
  assign pay_o       = {hit5_q, np5_q, tq5_q, pt5_q[2], pt5_q[1], pt5_q[0],
                        negs5_q, negt5_q, zs5_q, zt5_q};

endmodule

/* rtl/ray_plane_intersect_texcoord_top.sv */
// ----------------------------------------------------------------------------
// ray_plane_intersect_texcoord_top
// Ray / plane intersection with hit point and planar texture coordinates.
// ----------------------------------------------------------------------------
// A ray item enters on ray_i (valid / ready) and exactly one result item
// leaves on res_o, in order. Plane and texture registers are to be written
// through cfg_we_i / cfg_idx_i / cfg_wdata_i only while no item is in
// flight; the user must keep to this, the block does not enforce it. From
// acceptance to the result register an item passes the normal dot product
// stages, the t divider (overflow check plus one quotient bit a stage), the
// hit point and axis product stages, the two texture dividers and 1 output
// register. Throughput is one item per cycle while res_o does not stall;
// each stage holds one item and passes it on whenever the next stage is
// empty or moving. When res_o.ready is low the result register holds and
// the stall reaches back stage by stage; empty stages still fill, so
// ray_i.ready only drops once every stage holds an item.
// Reset clears all stage valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module ray_plane_intersect_texcoord_top #(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 12,
  localparam int W     = COORD_WIDTH,
  localparam int CFG_W = (3 * W > 3 * rpi_pkg::NORM_WIDTH) ? 3 * W : 3 * rpi_pkg::NORM_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rpi_ray_if.sink                       ray_i,
  rpi_result_if.source                  res_o,
  input  logic                          cfg_we_i,
  input  logic [rpi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_wdata_i
);

  localparam int NW   = rpi_pkg::NORM_WIDTH;
  localparam int SW   = rpi_pkg::SCALAR_WIDTH;
  localparam int PRW  = NW + W + 2;
  localparam int NUMW = ((SW + rpi_pkg::NORM_FRAC > PRW) ? SW + rpi_pkg::NORM_FRAC : PRW) + 1;
  localparam int DNW  = NUMW + FRAC_BITS;
  localparam int PAYW = 6 * W + SW + 2;
  localparam int DOTW = 2 * W + 3;
  localparam int LENW = 2 * W + 2;
  localparam int TNW  = DOTW + FRAC_BITS;
  localparam int PAY2 = SW + 3 * W + 6;
  localparam int TQW  = SW - 1;
  // register bits from 64 upwards are not kept
  localparam int KEEP = (3 * W > 64) ? 64 : 3 * W;
  localparam logic [3*W-1:0] TEX_MASK = {(3*W){1'b1}} >> (3 * W - KEEP);

  // configuration
  logic [3*NW-1:0]      normal_q;
  logic signed [SW-1:0] offset_q;
  logic [3*W-1:0]       torg_q, tu_q, tv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q <= '0;
      offset_q <= '0;
      torg_q   <= '0;
      tu_q     <= '0;
      tv_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (rpi_pkg::rpi_reg_e'(cfg_idx_i))
        rpi_pkg::REG_PLANE_NORMAL:   normal_q <= cfg_wdata_i[3*NW-1:0];
        rpi_pkg::REG_PLANE_OFFSET:   offset_q <= cfg_wdata_i[SW-1:0];
        rpi_pkg::REG_TEXTURE_ORIGIN: torg_q   <= cfg_wdata_i[3*W-1:0] & TEX_MASK;
        rpi_pkg::REG_TEXTURE_U_AXIS: tu_q     <= cfg_wdata_i[3*W-1:0] & TEX_MASK;
        rpi_pkg::REG_TEXTURE_V_AXIS: tv_q     <= cfg_wdata_i[3*W-1:0] & TEX_MASK;
        default: ;
      endcase
    end
  end

  // front: normal dot products
  logic signed [W-1:0] org_in [3], dir_in [3];
  logic                dot_valid, dot_ready;
  logic [DNW-1:0]      dot_num;
  logic [PRW-1:0]      dot_den;
  logic [PAYW-1:0]     dot_pay;

  assign org_in[0] = ray_i.origin_x;
  assign org_in[1] = ray_i.origin_y;
  assign org_in[2] = ray_i.origin_z;
  assign dir_in[0] = ray_i.dir_x;
  assign dir_in[1] = ray_i.dir_y;
  assign dir_in[2] = ray_i.dir_z;

  rpi_plane_dot #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ray_i.valid),
    .in_ready_o  (ray_i.ready),
    .org_i       (org_in),
    .dir_i       (dir_in),
    .limit_i     (ray_i.max_distance),
    .normal_i    (normal_q),
    .offset_i    (offset_q),
    .out_valid_o (dot_valid),
    .out_ready_i (dot_ready),
    .num_o       (dot_num),
    .den_o       (dot_den),
    .pay_o       (dot_pay)
  );

  // ray parameter division
  logic [DNW-1:0]  tdiv_num [1];
  logic [PRW-1:0]  tdiv_den [1];
  logic [SW-1:0]   tdiv_quo [1];
  logic [0:0]      tdiv_ovf;
  logic            tdiv_valid, tdiv_ready;
  logic [PAYW-1:0] tdiv_pay;

  assign tdiv_num[0] = dot_num;
  assign tdiv_den[0] = dot_den;

  rpi_div_pipe #(
    .LANES (1),
    .NW    (DNW),
    .DW    (PRW),
    .QW    (SW),
    .PW    (PAYW)
  ) u_tdiv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dot_valid),
    .in_ready_o  (dot_ready),
    .num_i       (tdiv_num),
    .den_i       (tdiv_den),
    .pay_i       (dot_pay),
    .out_valid_o (tdiv_valid),
    .out_ready_i (tdiv_ready),
    .quo_o       (tdiv_quo),
    .ovf_o       (tdiv_ovf),
    .pay_o       (tdiv_pay)
  );

  // hit point and texture set-up
  logic            ht_valid, ht_ready;
  logic [TNW-1:0]  ht_num [2];
  logic [LENW-1:0] ht_den [2];
  logic [PAY2-1:0] ht_pay;

  rpi_hit_tex #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_hit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tdiv_valid),
    .in_ready_o  (tdiv_ready),
    .quo_i       (tdiv_quo[0]),
    .ovf_i       (tdiv_ovf[0]),
    .pay_i       (tdiv_pay),
    .torg_i      (torg_q),
    .tu_i        (tu_q),
    .tv_i        (tv_q),
    .out_valid_o (ht_valid),
    .out_ready_i (ht_ready),
    .num_o       (ht_num),
    .den_o       (ht_den),
    .pay_o       (ht_pay)
  );

  // texture coordinate divisions, s and t side by side
  logic [TQW-1:0]  xdiv_quo [2];
  logic [1:0]      xdiv_ovf;
  logic            xdiv_valid, xdiv_ready;
  logic [PAY2-1:0] xdiv_pay;

  rpi_div_pipe #(
    .LANES (2),
    .NW    (TNW),
    .DW    (LENW),
    .QW    (TQW),
    .PW    (PAY2)
  ) u_xdiv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ht_valid),
    .in_ready_o  (ht_ready),
    .num_i       (ht_num),
    .den_i       (ht_den),
    .pay_i       (ht_pay),
    .out_valid_o (xdiv_valid),
    .out_ready_i (xdiv_ready),
    .quo_o       (xdiv_quo),
    .ovf_o       (xdiv_ovf),
    .pay_o       (xdiv_pay)
  );

  // result register
  logic                f_hit, f_np;
  logic [SW-1:0]       f_tq;
  logic signed [W-1:0] f_pt [3];
  logic [1:0]          f_neg, f_zero;
  logic signed [SW-1:0] tex_d [2];

  assign f_zero[1] = xdiv_pay[0];
  assign f_zero[0] = xdiv_pay[1];
  assign f_neg[1]  = xdiv_pay[2];
  assign f_neg[0]  = xdiv_pay[3];
  assign f_tq      = xdiv_pay[4 + 3*W +: SW];
  assign f_np      = xdiv_pay[4 + 3*W + SW];
  assign f_hit     = xdiv_pay[5 + 3*W + SW];

  for (genvar i = 0; i < 3; i++) begin : g_pt
    assign f_pt[i] = xdiv_pay[4 + W*i +: W];
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (!f_hit || f_zero[l]) begin
        tex_d[l] = '0;
      end else if (xdiv_ovf[l]) begin
        // saturate: a negative value of exactly -2^23 lands on the same code
        tex_d[l] = f_neg[l] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
        tex_d[l] = f_neg[l] ? -SW'(xdiv_quo[l]) : SW'(xdiv_quo[l]);
      end
    end
  end

  logic                 ov_q;
  logic                 hit_q, np_q;
  logic [SW-1:0]        dist_q;
  logic signed [W-1:0]  pt_q [3];
  logic signed [SW-1:0] tex_q [2];

  assign xdiv_ready = !ov_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (xdiv_ready) begin
      ov_q <= xdiv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xdiv_ready) begin
      hit_q  <= f_hit;
      np_q   <= f_np;
      dist_q <= f_hit ? f_tq : '0;
      for (int i = 0; i < 3; i++) begin
        pt_q[i] <= f_hit ? f_pt[i] : '0;
      end
      tex_q <= tex_d;
    end
  end

  assign res_o.valid        = ov_q;
  assign res_o.hit          = hit_q;
  assign res_o.not_parallel = np_q;
  assign res_o.hit_distance = dist_q;
  assign res_o.point_x      = pt_q[0];
  assign res_o.point_y      = pt_q[1];
  assign res_o.point_z      = pt_q[2];
  assign res_o.tex_s        = tex_q[0];
  assign res_o.tex_t        = tex_q[1];

endmodule

/* rtl/rpi_checker.sv */
// ----------------------------------------------------------------------------
// rpi_checker
// Port-level checks of the result channel of the intersection block.
// ----------------------------------------------------------------------------
module rpi_checker #(
  parameter int COORD_WIDTH = 20
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              res_valid_i,
  input logic                              res_ready_i,
  input logic                              hit_i,
  input logic                              not_parallel_i,
  input logic [rpi_pkg::SCALAR_WIDTH-1:0]  hit_distance_i,
  input logic [COORD_WIDTH-1:0]            point_x_i,
  input logic [COORD_WIDTH-1:0]            point_y_i,
  input logic [COORD_WIDTH-1:0]            point_z_i,
  input logic [rpi_pkg::SCALAR_WIDTH-1:0]  tex_s_i,
  input logic [rpi_pkg::SCALAR_WIDTH-1:0]  tex_t_i
);

  // a stalled result stays valid and keeps its hit flag, distance, point_x and texture coordinates
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(hit_i) && $stable(hit_distance_i)
      && $stable(point_x_i) && $stable(tex_s_i) && $stable(tex_t_i))
    else $error("result changed while stalled");

  // a miss carries only the parallel flag
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !hit_i |-> hit_distance_i == '0 && point_x_i == '0 && point_y_i == '0
      && point_z_i == '0 && tex_s_i == '0 && tex_t_i == '0)
    else $error("miss with nonzero fields");

  // a hit needs a non-parallel ray and a positive distance
  a_hit_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && hit_i |-> not_parallel_i && hit_distance_i != '0)
    else $error("hit without positive distance or on parallel ray");

endmodule

bind ray_plane_intersect_texcoord_top rpi_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_rpi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .hit_i          (res_o.hit),
  .not_parallel_i (res_o.not_parallel),
  .hit_distance_i (res_o.hit_distance),
  .point_x_i      (res_o.point_x),
  .point_y_i      (res_o.point_y),
  .point_z_i      (res_o.point_z),
  .tex_s_i        (res_o.tex_s),
  .tex_t_i        (res_o.tex_t)
);
